### rtl/clc_pkg.sv
// ----------------------------------------------------------------------------
// Crossing light controller package
// Beat types, mode and colour codes, register indexes and reset values that
// are shared by the controller's modules.
// ----------------------------------------------------------------------------
package clc_pkg;

    // Field widths fixed by the interface.
    localparam int FUNC_W   = 2;
    localparam int POT_W    = 12;
    localparam int COLOUR_W = 3;
    localparam int DUTY_W   = 14;
    localparam int MODE_W   = 2;
    localparam int THRESH_W = 10;
    localparam int BLINK_W  = 8;
    localparam int CFG_IDX_W = 3;

    // Gate servo duty mapping, hundredths of a percent.
    localparam logic [DUTY_W-1:0] DUTY_BASE = 14'd700;
    localparam logic [8:0]        DUTY_SPAN = 9'd475;

    // Register reset values.
    localparam logic [THRESH_W-1:0] YELLOW_TICKS_RST    = 10'd30;
    localparam logic [THRESH_W-1:0] WALK_RED_END_RST    = 10'd130;
    localparam logic [THRESH_W-1:0] WALK_YELLOW_END_RST = 10'd160;
    localparam logic [BLINK_W-1:0]  BLINK_PERIOD_RST    = 8'd20;
    localparam logic [BLINK_W-1:0]  BLINK_ON_TICKS_RST  = 8'd10;
    localparam logic [DUTY_W-1:0]   DUTY_CLOSED_RST     = 14'd700;
    localparam logic [DUTY_W-1:0]   DUTY_OPEN_RST       = 14'd1175;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_RED_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WALK_YELLOW_END = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON_TICKS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CLOSED     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_OPEN       = 3'd6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_BUTTON = 2'd1,
        FUNC_MAINT  = 2'd2,
        FUNC_TRAIN  = 2'd3
    } t_func;

    typedef enum logic [MODE_W-1:0] {
        MODE_TRAFFIC = 2'd0,
        MODE_WALK    = 2'd1,
        MODE_TRAIN   = 2'd2,
        MODE_MAINT   = 2'd3
    } t_mode;

    typedef enum logic [COLOUR_W-1:0] {
        COL_OFF    = 3'd0,
        COL_GREEN  = 3'd1,
        COL_YELLOW = 3'd2,
        COL_RED    = 3'd3,
        COL_BLUE   = 3'd4
    } t_colour;

    typedef struct packed {
        t_func              func;
        logic [POT_W-1:0]   pot_level;
    } t_in_item;

    typedef struct packed {
        t_colour            light_colour;
        logic               gate_is_closed;
        logic               led_bank_on;
        logic [DUTY_W-1:0]  servo_duty;
        t_mode              mode;
    } t_out_item;

    typedef struct packed {
        logic [THRESH_W-1:0] yellow_ticks;
        logic [THRESH_W-1:0] walk_red_end;
        logic [THRESH_W-1:0] walk_yellow_end;
        logic [BLINK_W-1:0]  blink_period;
        logic [BLINK_W-1:0]  blink_on_ticks;
        logic [DUTY_W-1:0]   duty_closed;
        logic [DUTY_W-1:0]   duty_open;
    } t_cfg;

endpackage

### rtl/clc_cfg.sv
// ----------------------------------------------------------------------------
// Crossing light controller configuration registers
// Holds the seven timing and duty registers, written one beat at a time.
// ----------------------------------------------------------------------------
module clc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [clc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [clc_pkg::DUTY_W-1:0]    i_cfg_data,
    output clc_pkg::t_cfg                 o_cfg
);

    clc_pkg::t_cfg r_cfg;

    // Writes are always taken at once.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register file; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.yellow_ticks    <= clc_pkg::YELLOW_TICKS_RST;
            r_cfg.walk_red_end    <= clc_pkg::WALK_RED_END_RST;
            r_cfg.walk_yellow_end <= clc_pkg::WALK_YELLOW_END_RST;
            r_cfg.blink_period    <= clc_pkg::BLINK_PERIOD_RST;
            r_cfg.blink_on_ticks  <= clc_pkg::BLINK_ON_TICKS_RST;
            r_cfg.duty_closed     <= clc_pkg::DUTY_CLOSED_RST;
            r_cfg.duty_open       <= clc_pkg::DUTY_OPEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clc_pkg::CFG_YELLOW_TICKS: begin
                    r_cfg.yellow_ticks <= i_cfg_data[clc_pkg::THRESH_W-1:0];
                end
                clc_pkg::CFG_WALK_RED_END: begin
                    r_cfg.walk_red_end <= i_cfg_data[clc_pkg::THRESH_W-1:0];
                end
                clc_pkg::CFG_WALK_YELLOW_END: begin
                    r_cfg.walk_yellow_end <= i_cfg_data[clc_pkg::THRESH_W-1:0];
                end
                clc_pkg::CFG_BLINK_PERIOD: begin
                    r_cfg.blink_period <= i_cfg_data[clc_pkg::BLINK_W-1:0];
                end
                clc_pkg::CFG_BLINK_ON_TICKS: begin
                    r_cfg.blink_on_ticks <= i_cfg_data[clc_pkg::BLINK_W-1:0];
                end
                clc_pkg::CFG_DUTY_CLOSED: begin
                    r_cfg.duty_closed <= i_cfg_data;
                end
                clc_pkg::CFG_DUTY_OPEN: begin
                    r_cfg.duty_open <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/clc_duty.sv
// ----------------------------------------------------------------------------
// Crossing light controller servo duty mapping
// Scales a potentiometer sample onto the gate servo duty range, rounds it and
// clamps it between the closed and open duties.
// ----------------------------------------------------------------------------
module clc_duty #(
    parameter int POT_BITS = 12
) (
    input  logic [clc_pkg::POT_W-1:0]  i_pot_level,
    input  logic [clc_pkg::DUTY_W-1:0] i_duty_closed,
    input  logic [clc_pkg::DUTY_W-1:0] i_duty_open,
    output logic [clc_pkg::DUTY_W-1:0] o_duty
);

    localparam int PROD_W = POT_BITS + 10;

    logic [POT_BITS-1:0]    w_pot;
    logic [PROD_W-1:0]      w_prod;
    logic [8:0]             w_scaled;
    logic [clc_pkg::DUTY_W-1:0] w_raw;

    // Only the low POT_BITS bits of the sample count.
    assign w_pot = POT_BITS'(i_pot_level);

    // Multiply by the span, add one half and drop the fraction bits.
    assign w_prod = PROD_W'(w_pot) * PROD_W'(clc_pkg::DUTY_SPAN)
                  + (PROD_W'(1) << (POT_BITS - 1));
    assign w_scaled = w_prod[POT_BITS+8:POT_BITS];
    assign w_raw    = clc_pkg::DUTY_BASE + clc_pkg::DUTY_W'(w_scaled);

    // When the two limits cross, a value above the open duty takes the open duty and any other takes the closed duty.
    always_comb begin
        if (w_raw > i_duty_open) begin
            o_duty = i_duty_open;
        end else if (w_raw < i_duty_closed) begin
            o_duty = i_duty_closed;
        end else begin
            o_duty = w_raw;
        end
    end

endmodule

### rtl/clc_core.sv
// ----------------------------------------------------------------------------
// Crossing light controller core
// Mode, tick count, blink phase and output state, stepped once for every
// beat that passes from the input register to the result register.
// ----------------------------------------------------------------------------
module clc_core #(
    parameter int COUNT_BITS = 16,
    parameter int POT_BITS   = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  clc_pkg::t_in_item  i_item,
    input  clc_pkg::t_cfg      i_cfg,
    output clc_pkg::t_out_item o_result
);

    localparam int CMP_W = (COUNT_BITS > clc_pkg::THRESH_W) ? COUNT_BITS
                                                            : clc_pkg::THRESH_W;

    clc_pkg::t_mode          r_mode,    n_mode;
    logic [COUNT_BITS-1:0]   r_ticks,   n_ticks;
    logic [clc_pkg::BLINK_W-1:0] r_phase, n_phase;
    logic                    r_changed, n_changed;
    logic                    r_train,   n_train;
    logic                    r_maint,   n_maint;
    clc_pkg::t_colour        r_light,   n_light;
    logic                    r_gate,    n_gate;
    logic                    r_bank,    n_bank;
    logic [clc_pkg::DUTY_W-1:0] r_duty, n_duty;

    logic [clc_pkg::DUTY_W-1:0]  w_pot_duty;
    logic [clc_pkg::BLINK_W:0]   w_phase_inc;
    logic [clc_pkg::BLINK_W:0]   w_period;
    logic [CMP_W-1:0]            w_count;
    logic                        w_le_yellow;
    logic                        w_le_red;
    logic                        w_le_walk_yellow;
    clc_pkg::t_mode              w_seen;

    clc_duty #(
        .POT_BITS      (POT_BITS)
    ) u_duty (
        .i_pot_level   (i_item.pot_level),
        .i_duty_closed (i_cfg.duty_closed),
        .i_duty_open   (i_cfg.duty_open),
        .o_duty        (w_pot_duty)
    );

    // A zero period behaves as a period of one.
    assign w_phase_inc = {1'b0, r_phase} + 9'd1;
    assign w_period    = (i_cfg.blink_period == '0) ? 9'd1 : {1'b0, i_cfg.blink_period};

    // Threshold compares run on the count after this tick.
    assign w_count          = CMP_W'(n_ticks);
    assign w_le_yellow      = w_count <= CMP_W'(i_cfg.yellow_ticks);
    assign w_le_red         = w_count <= CMP_W'(i_cfg.walk_red_end);
    assign w_le_walk_yellow = w_count <= CMP_W'(i_cfg.walk_yellow_end);

    // Tick count and blink phase update.
    always_comb begin
        n_ticks = r_ticks;
        n_phase = r_phase;
        if (i_item.func == clc_pkg::FUNC_TICK) begin
            if (r_changed) begin
                n_ticks = '0;
                n_phase = '0;
            end else begin
                if (r_ticks != '1) begin
                    n_ticks = r_ticks + COUNT_BITS'(1);
                end
                n_phase = (w_phase_inc >= w_period) ? '0
                                                    : w_phase_inc[clc_pkg::BLINK_W-1:0];
            end
        end
    end

    // Mode, light, gate, bank and duty update.
    always_comb begin
        n_mode    = r_mode;
        n_changed = r_changed;
        n_train   = r_train;
        n_maint   = r_maint;
        n_light   = r_light;
        n_gate    = r_gate;
        n_bank    = r_bank;
        n_duty    = r_duty;
        w_seen    = r_mode;

        case (i_item.func)
            clc_pkg::FUNC_TICK: begin
                n_changed = 1'b0;
                case (r_mode)
                    clc_pkg::MODE_TRAFFIC: begin
                        n_light = w_le_yellow ? clc_pkg::COL_YELLOW : clc_pkg::COL_GREEN;
                    end
                    clc_pkg::MODE_WALK: begin
                        if (w_le_yellow) begin
                            n_light = clc_pkg::COL_YELLOW;
                        end else if (w_le_red) begin
                            n_light = clc_pkg::COL_RED;
                        end else if (w_le_walk_yellow) begin
                            n_light = clc_pkg::COL_YELLOW;
                        end else begin
                            n_light = clc_pkg::COL_GREEN;
                            n_mode  = clc_pkg::MODE_TRAFFIC;
                        end
                    end
                    clc_pkg::MODE_TRAIN: begin
                        n_light = w_le_yellow ? clc_pkg::COL_YELLOW : clc_pkg::COL_RED;
                    end
                    default: begin
                        n_duty  = w_pot_duty;
                        n_light = (n_phase <= i_cfg.blink_on_ticks) ? clc_pkg::COL_BLUE
                                                                    : clc_pkg::COL_OFF;
                    end
                endcase
            end
            clc_pkg::FUNC_BUTTON: begin
                w_seen = clc_pkg::MODE_WALK;
            end
            clc_pkg::FUNC_MAINT: begin
                n_maint = !r_maint;
            end
            default: begin
                n_train = !r_train;
                if (!r_train) begin
                    w_seen = clc_pkg::MODE_TRAIN;
                end
            end
        endcase

        // Events act on the mode they see; train wins in traffic and walk.
        if (i_item.func != clc_pkg::FUNC_TICK) begin
            n_mode = w_seen;
            case (w_seen)
                clc_pkg::MODE_TRAFFIC, clc_pkg::MODE_WALK: begin
                    n_gate = 1'b0;
                    n_bank = (w_seen == clc_pkg::MODE_WALK);
                    n_duty = i_cfg.duty_open;
                    if (n_train) begin
                        n_mode = clc_pkg::MODE_TRAIN;
                    end else if (n_maint) begin
                        n_mode = clc_pkg::MODE_MAINT;
                    end
                end
                clc_pkg::MODE_TRAIN: begin
                    n_gate = 1'b1;
                    n_bank = 1'b0;
                    n_duty = i_cfg.duty_closed;
                    if (!n_train) begin
                        n_mode = clc_pkg::MODE_TRAFFIC;
                    end else if (n_maint) begin
                        n_mode = clc_pkg::MODE_MAINT;
                    end
                end
                default: begin
                    n_gate = 1'b1;
                    n_bank = 1'b0;
                    n_duty = i_cfg.duty_closed;
                    if (!n_maint) begin
                        n_mode = clc_pkg::MODE_TRAFFIC;
                    end
                end
            endcase
        end

        // Any change of mode restarts the count on the next tick.
        if (n_mode != r_mode) begin
            n_changed = 1'b1;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= clc_pkg::MODE_TRAFFIC;
            r_ticks   <= '0;
            r_phase   <= '0;
            r_changed <= 1'b0;
            r_train   <= 1'b0;
            r_maint   <= 1'b0;
            r_light   <= clc_pkg::COL_OFF;
            r_gate    <= 1'b0;
            r_bank    <= 1'b0;
            r_duty    <= clc_pkg::DUTY_OPEN_RST;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_ticks   <= n_ticks;
            r_phase   <= n_phase;
            r_changed <= n_changed;
            r_train   <= n_train;
            r_maint   <= n_maint;
            r_light   <= n_light;
            r_gate    <= n_gate;
            r_bank    <= n_bank;
            r_duty    <= n_duty;
        end
    end

    // The result shows the state after this beat.
    assign o_result.light_colour   = n_light;
    assign o_result.gate_is_closed = n_gate;
    assign o_result.led_bank_on    = n_bank;
    assign o_result.servo_duty     = n_duty;
    assign o_result.mode           = n_mode;

endmodule

### rtl/crossing_light_controller.sv
// ----------------------------------------------------------------------------
// Crossing light controller
// Road and rail crossing controller: traffic, pedestrian, train and
// maintenance modes driving the light, gate, LED bank and servo duty.
// ----------------------------------------------------------------------------
// The controller takes one beat per clock cycle unless held back, and gives
// exactly one result beat for each input beat, in order. A beat is held in an
// input register, stepped through the mode and timing logic and lands in a
// result register. The result register lets the next input beat be taken
// while a result is still waiting on the output side; only a full result
// register that is not being drained, together with a full input register,
// holds the input back. Configuration writes are taken in any cycle and
// should be made while no beat is in flight.
module crossing_light_controller #(
    parameter int COUNT_BITS = 16,
    parameter int POT_BITS   = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  clc_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output clc_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [clc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [clc_pkg::DUTY_W-1:0]    i_cfg_data
);

    logic               r_in_valid;
    clc_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    clc_pkg::t_out_item r_out_item;
    logic               w_fire;
    clc_pkg::t_cfg      w_cfg;
    clc_pkg::t_out_item w_result;

    clc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    clc_core #(
        .COUNT_BITS (COUNT_BITS),
        .POT_BITS   (POT_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_item     (r_in_item),
        .i_cfg      (w_cfg),
        .o_result   (w_result)
    );

    // A held beat moves on when the result register is free or draining.
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

### rtl/clc_checker.sv
// ----------------------------------------------------------------------------
// Crossing light controller checker
// Port-level assertions on the controller, bound to the top level.
// ----------------------------------------------------------------------------
module clc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  clc_pkg::t_out_item o_out_data
);

    // A result beat that is stalled keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result beat changed while stalled");

    // No result beat is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // With the result side empty the input side never stalls.
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // The LED bank is lit only while the gate is open.
    a_bank_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.led_bank_on) |-> !o_out_data.gate_is_closed)
        else $error("LED bank lit with gate closed");

endmodule

bind crossing_light_controller clc_checker u_clc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
